// ----- hdl/ible_pkg.sv -----
package ible_pkg;

	localparam int MODE_W = 4;
	localparam int POS_W = 7;
	localparam int VAL_W = 8;
	localparam int ST_W = 2;
	localparam int CNT_OUT_W = 7;
	localparam int IN_W = 24;
	localparam int OUT_W = 40;

	localparam logic [MODE_W-1:0] MODE_PUSH_BACK = 4'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 4'd1;
	localparam logic [MODE_W-1:0] MODE_INSERT_AT = 4'd2;
	localparam logic [MODE_W-1:0] MODE_INSERT_SORTED = 4'd3;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT = 4'd4;
	localparam logic [MODE_W-1:0] MODE_POP_BACK = 4'd5;
	localparam logic [MODE_W-1:0] MODE_REMOVE_AT = 4'd6;
	localparam logic [MODE_W-1:0] MODE_REPLACE_AT = 4'd7;
	localparam logic [MODE_W-1:0] MODE_READ_AT = 4'd8;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 4'd9;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL = 2'd3;

	typedef enum logic [2:0] {
		IDX_KEEP,
		IDX_ZERO,
		IDX_COUNT,
		IDX_POS,
		IDX_CNT_M1,
		IDX_INC,
		IDX_DEC
	} idx_sel_t;

	typedef enum logic [2:0] {
		AT_KEEP,
		AT_ZERO,
		AT_COUNT,
		AT_POS,
		AT_IDX
	} at_sel_t;

	typedef enum logic [2:0] {
		RA_IDX,
		RA_IDX_M1,
		RA_IDX_P1,
		RA_ZERO,
		RA_LAST
	} ra_sel_t;

	typedef enum logic {
		WD_VAL,
		WD_RDATA
	} wd_sel_t;

	typedef enum logic [1:0] {
		CNT_KEEP,
		CNT_INC,
		CNT_DEC,
		CNT_CLR
	} cnt_op_t;

	typedef struct packed {
		logic cap;
		idx_sel_t idx_sel;
		at_sel_t at_sel;
		logic rd_en;
		ra_sel_t ra_sel;
		logic wr_en;
		wd_sel_t wd_sel;
		cnt_op_t cnt_op;
		logic st_ld;
		logic [ST_W-1:0] st_code;
		logic rv_ld;
		logic first_ld;
		logic last_ld;
		logic res_ld;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic empty;
		logic full;
		logic pos_gt_cnt;
		logic pos_ge_cnt;
		logic idx_gt_at;
		logic idx_p1_lt_cnt;
		logic idx_lt_cnt;
		logic rd_ge_val;
	} flags_t;

endpackage

// ----- hdl/indexed_byte_list_engine_top.sv -----
// Ordered list of up to CAPACITY signed bytes held in a single-port RAM, with one
// request word in and one result word out per request. A request is taken only
// when the engine is idle; a finished result may still wait on the output while
// the next request is taken. Every request, also a rejected one or an unused mode,
// ends by reading the front and back bytes unless it leaves the list empty.
// A replace adds one write and a read adds one read. An insert or a remove moves
// its elements one at a time (inserts move count-index cells, removes move
// count-index-1 cells). A sorted insert first compares the stored bytes in turn,
// up to and including the first one not below the new byte. A result that is
// still held on the output stalls the engine once the next result is ready.
// The element RAM does one read and one write per moved cell, plus two reads at
// the end for the front and back bytes.
module indexed_byte_list_engine_top #(
	parameter int CAPACITY = 64
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// mode[3:0], position[10:4], value[18:11], zero[23:19]
	input logic [ible_pkg::IN_W-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// status[1:0], read_value[9:2], item_count[16:10], first_item[24:17],
	// last_item[32:25], is_empty[33], zero[39:34]
	output logic [ible_pkg::OUT_W-1:0] m_tdata
);
	import ible_pkg::*;

	cmd_t cmd;
	flags_t flags;

	logic [ST_W-1:0] status;
	logic signed [VAL_W-1:0] read_value;
	logic [CNT_OUT_W-1:0] item_count;
	logic signed [VAL_W-1:0] first_item;
	logic signed [VAL_W-1:0] last_item;
	logic is_empty;

	ible_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.flags(flags),
		.cmd(cmd)
	);

	ible_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.flags(flags),
		.mode(s_tdata[3:0]),
		.position(s_tdata[10:4]),
		.value(s_tdata[18:11]),
		.status(status),
		.read_value(read_value),
		.item_count(item_count),
		.first_item(first_item),
		.last_item(last_item),
		.is_empty(is_empty)
	);

	assign m_tdata = {6'b0, is_empty, last_item, first_item, item_count, read_value, status};

endmodule

// ----- hdl/ible_dp.sv -----
module ible_dp #(
	parameter int CAPACITY = 64
) (
	input logic clk,
	input logic arst_n,
	input ible_pkg::cmd_t cmd,
	output ible_pkg::flags_t flags,
	input logic [ible_pkg::MODE_W-1:0] mode,
	input logic [ible_pkg::POS_W-1:0] position,
	input logic signed [ible_pkg::VAL_W-1:0] value,
	output logic [ible_pkg::ST_W-1:0] status,
	output logic signed [ible_pkg::VAL_W-1:0] read_value,
	output logic [ible_pkg::CNT_OUT_W-1:0] item_count,
	output logic signed [ible_pkg::VAL_W-1:0] first_item,
	output logic signed [ible_pkg::VAL_W-1:0] last_item,
	output logic is_empty
);
	import ible_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int MW = (CW > POS_W) ? CW : POS_W;

	logic [VAL_W-1:0] mem_q [CAPACITY];
	logic [VAL_W-1:0] rdata_q;

	logic [MODE_W-1:0] mode_q;
	logic [POS_W-1:0] pos_q;
	logic signed [VAL_W-1:0] val_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] at_q;
	logic [ST_W-1:0] status_q;
	logic [VAL_W-1:0] read_val_q;
	logic [VAL_W-1:0] first_q;
	logic [VAL_W-1:0] last_q;

	logic [ST_W-1:0] res_status_q;
	logic [VAL_W-1:0] res_read_q;
	logic [CNT_OUT_W-1:0] res_count_q;
	logic [VAL_W-1:0] res_first_q;
	logic [VAL_W-1:0] res_last_q;
	logic res_empty_q;

	logic [CW-1:0] idx_m1;
	logic [CW-1:0] idx_p1;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] pos_c;
	logic [CW-1:0] ra_full;
	logic [VAL_W-1:0] wdata;
	logic cnt_zero;

	assign idx_m1 = idx_q - CW'(1);
	assign idx_p1 = idx_q + CW'(1);
	assign cnt_m1 = count_q - CW'(1);
	assign pos_c = CW'(pos_q);
	assign cnt_zero = (count_q == '0);

	always_comb begin
		case (cmd.ra_sel)
			RA_IDX: ra_full = idx_q;
			RA_IDX_M1: ra_full = idx_m1;
			RA_IDX_P1: ra_full = idx_p1;
			RA_ZERO: ra_full = '0;
			RA_LAST: ra_full = cnt_m1;
			default: ra_full = idx_q;
		endcase
	end

	assign wdata = (cmd.wd_sel == WD_RDATA) ? rdata_q : val_q;

	// single port element store, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[idx_q[AW-1:0]] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[ra_full[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.cnt_op)
				CNT_INC: count_q <= count_q + CW'(1);
				CNT_DEC: count_q <= cnt_m1;
				CNT_CLR: count_q <= '0;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			mode_q <= mode;
			pos_q <= position;
			val_q <= value;
			status_q <= ST_OK;
			read_val_q <= '0;
		end else begin
			if (cmd.st_ld) begin
				status_q <= cmd.st_code;
			end
			if (cmd.rv_ld) begin
				read_val_q <= rdata_q;
			end
		end
		case (cmd.idx_sel)
			IDX_ZERO: idx_q <= '0;
			IDX_COUNT: idx_q <= count_q;
			IDX_POS: idx_q <= pos_c;
			IDX_CNT_M1: idx_q <= cnt_m1;
			IDX_INC: idx_q <= idx_p1;
			IDX_DEC: idx_q <= idx_m1;
			default: idx_q <= idx_q;
		endcase
		case (cmd.at_sel)
			AT_ZERO: at_q <= '0;
			AT_COUNT: at_q <= count_q;
			AT_POS: at_q <= pos_c;
			AT_IDX: at_q <= idx_q;
			default: at_q <= at_q;
		endcase
		if (cmd.first_ld) begin
			first_q <= rdata_q;
		end
		if (cmd.last_ld) begin
			last_q <= rdata_q;
		end
		if (cmd.res_ld) begin
			res_status_q <= status_q;
			res_read_q <= read_val_q;
			res_count_q <= CNT_OUT_W'(count_q);
			res_first_q <= cnt_zero ? '0 : first_q;
			res_last_q <= cnt_zero ? '0 : last_q;
			res_empty_q <= cnt_zero;
		end
	end

	always_comb begin
		flags.mode = mode_q;
		flags.empty = cnt_zero;
		flags.full = (count_q == CW'(CAPACITY));
		flags.pos_gt_cnt = (MW'(pos_q) > MW'(count_q));
		flags.pos_ge_cnt = (MW'(pos_q) >= MW'(count_q));
		flags.idx_gt_at = (idx_q > at_q);
		flags.idx_p1_lt_cnt = (idx_p1 < count_q);
		flags.idx_lt_cnt = (idx_q < count_q);
		flags.rd_ge_val = ($signed(rdata_q) >= val_q);
	end

	assign status = res_status_q;
	assign read_value = res_read_q;
	assign item_count = res_count_q;
	assign first_item = res_first_q;
	assign last_item = res_last_q;
	assign is_empty = res_empty_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count beyond capacity");

	a_write_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> idx_q < CW'(CAPACITY))
		else $error("store write outside capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> (count_q == $past(count_q) + CW'(1)
		|| count_q == $past(count_q) - CW'(1) || count_q == '0))
		else $error("element count jumped");
`endif

endmodule

// ----- hdl/ible_ctrl.sv -----
module ible_ctrl (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input logic m_tready,
	input ible_pkg::flags_t flags,
	output ible_pkg::cmd_t cmd
);
	import ible_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE = 15'b000000000000001,
		S_DECIDE = 15'b000000000000010,
		S_SRCH_CHK = 15'b000000000000100,
		S_SRCH_CMP = 15'b000000000001000,
		S_SR_CHK = 15'b000000000010000,
		S_SR_WR = 15'b000000000100000,
		S_SL_CHK = 15'b000000001000000,
		S_SL_WR = 15'b000000010000000,
		S_REPL = 15'b000000100000000,
		S_RD_ISSUE = 15'b000001000000000,
		S_RD_CAP = 15'b000010000000000,
		S_FIRST = 15'b000100000000000,
		S_LAST = 15'b001000000000000,
		S_LAST_CAP = 15'b010000000000000,
		S_RESULT = 15'b100000000000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic out_valid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.cap = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_FIRST;
				case (flags.mode)
					MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
						if (flags.full) begin
							cmd.st_ld = 1'b1;
							cmd.st_code = ST_FULL;
						end else begin
							cmd.at_sel = (flags.mode == MODE_PUSH_BACK) ? AT_COUNT : AT_ZERO;
							cmd.idx_sel = IDX_COUNT;
							state_d = S_SR_CHK;
						end
					end
					MODE_INSERT_AT: begin
						if (flags.pos_gt_cnt) begin
							cmd.st_ld = 1'b1;
							cmd.st_code = ST_RANGE;
						end else if (flags.full) begin
							cmd.st_ld = 1'b1;
							cmd.st_code = ST_FULL;
						end else begin
							cmd.at_sel = AT_POS;
							cmd.idx_sel = IDX_COUNT;
							state_d = S_SR_CHK;
						end
					end
					MODE_INSERT_SORTED: begin
						if (flags.full) begin
							cmd.st_ld = 1'b1;
							cmd.st_code = ST_FULL;
						end else begin
							cmd.idx_sel = IDX_ZERO;
							state_d = S_SRCH_CHK;
						end
					end
					MODE_POP_FRONT, MODE_POP_BACK: begin
						if (flags.empty) begin
							cmd.st_ld = 1'b1;
							cmd.st_code = ST_EMPTY;
						end else begin
							cmd.idx_sel = (flags.mode == MODE_POP_FRONT) ? IDX_ZERO : IDX_CNT_M1;
							state_d = S_SL_CHK;
						end
					end
					MODE_REMOVE_AT, MODE_REPLACE_AT, MODE_READ_AT: begin
						if (flags.empty) begin
							cmd.st_ld = 1'b1;
							cmd.st_code = ST_EMPTY;
						end else if (flags.pos_ge_cnt) begin
							cmd.st_ld = 1'b1;
							cmd.st_code = ST_RANGE;
						end else begin
							cmd.idx_sel = IDX_POS;
							if (flags.mode == MODE_REMOVE_AT) begin
								state_d = S_SL_CHK;
							end else if (flags.mode == MODE_REPLACE_AT) begin
								state_d = S_REPL;
							end else begin
								state_d = S_RD_ISSUE;
							end
						end
					end
					MODE_CLEAR: begin
						cmd.cnt_op = CNT_CLR;
					end
					default: begin
						state_d = S_FIRST;
					end
				endcase
			end
			// linear scan for the first stored byte not below the new one
			S_SRCH_CHK: begin
				if (flags.idx_lt_cnt) begin
					cmd.rd_en = 1'b1;
					cmd.ra_sel = RA_IDX;
					state_d = S_SRCH_CMP;
				end else begin
					cmd.at_sel = AT_IDX;
					cmd.idx_sel = IDX_COUNT;
					state_d = S_SR_CHK;
				end
			end
			S_SRCH_CMP: begin
				if (flags.rd_ge_val) begin
					cmd.at_sel = AT_IDX;
					cmd.idx_sel = IDX_COUNT;
					state_d = S_SR_CHK;
				end else begin
					cmd.idx_sel = IDX_INC;
					state_d = S_SRCH_CHK;
				end
			end
			// open a gap, moving from the back towards the insert point
			S_SR_CHK: begin
				if (flags.idx_gt_at) begin
					cmd.rd_en = 1'b1;
					cmd.ra_sel = RA_IDX_M1;
					state_d = S_SR_WR;
				end else begin
					cmd.wr_en = 1'b1;
					cmd.wd_sel = WD_VAL;
					cmd.cnt_op = CNT_INC;
					state_d = S_FIRST;
				end
			end
			S_SR_WR: begin
				cmd.wr_en = 1'b1;
				cmd.wd_sel = WD_RDATA;
				cmd.idx_sel = IDX_DEC;
				state_d = S_SR_CHK;
			end
			// close a gap, moving from the removed cell towards the back
			S_SL_CHK: begin
				if (flags.idx_p1_lt_cnt) begin
					cmd.rd_en = 1'b1;
					cmd.ra_sel = RA_IDX_P1;
					state_d = S_SL_WR;
				end else begin
					cmd.cnt_op = CNT_DEC;
					state_d = S_FIRST;
				end
			end
			S_SL_WR: begin
				cmd.wr_en = 1'b1;
				cmd.wd_sel = WD_RDATA;
				cmd.idx_sel = IDX_INC;
				state_d = S_SL_CHK;
			end
			S_REPL: begin
				cmd.wr_en = 1'b1;
				cmd.wd_sel = WD_VAL;
				state_d = S_FIRST;
			end
			S_RD_ISSUE: begin
				cmd.rd_en = 1'b1;
				cmd.ra_sel = RA_IDX;
				state_d = S_RD_CAP;
			end
			S_RD_CAP: begin
				cmd.rv_ld = 1'b1;
				state_d = S_FIRST;
			end
			S_FIRST: begin
				if (flags.empty) begin
					state_d = S_RESULT;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.ra_sel = RA_ZERO;
					state_d = S_LAST;
				end
			end
			S_LAST: begin
				cmd.first_ld = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.ra_sel = RA_LAST;
				state_d = S_LAST_CAP;
			end
			S_LAST_CAP: begin
				cmd.last_ld = 1'b1;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (!out_valid_q || m_tready) begin
					cmd.res_ld = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_ld) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_ld |=> m_tvalid)
		else $error("loaded result not offered");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_ld |-> (!out_valid_q || m_tready))
		else $error("pending result overwritten");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import ible_pkg::*;

	localparam int CAPACITY = 64;
	localparam int RANDOM_ITEMS = 600;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [POS_W-1:0] position;
		logic signed [VAL_W-1:0] value;
		bit hold_for_idle;
	} list_req_t;

	typedef struct {
		logic [ST_W-1:0] status;
		logic signed [VAL_W-1:0] read_value;
		logic [CNT_OUT_W-1:0] item_count;
		logic signed [VAL_W-1:0] first_item;
		logic signed [VAL_W-1:0] last_item;
		logic is_empty;
	} list_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	list_req_t pending_reqs[$];
	list_result_t expected_results[$];

	logic signed [VAL_W-1:0] list_cells[CAPACITY];
	int list_len = 0;
	int peak_fill = 0;
	int gen_len = 0;

	list_req_t held_req;
	list_req_t head_req;
	list_result_t predicted;
	int gap_left = 0;
	int sent_count = 0;
	int got_count = 0;
	int out_stall = 0;
	int mismatches = 0;
	int full_rejects = 0;
	int range_rejects = 0;
	int empty_rejects = 0;

	indexed_byte_list_engine_top #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("timeout at %0t", $time);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int idle_cycles(input int n);
		if (((n / 40) % 4) == 1)
			return 0;
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 9);
	endfunction

	function automatic void open_slot(input int at, input logic signed [VAL_W-1:0] b);
		for (int i = list_len; i > at; i--)
			list_cells[i] = list_cells[i - 1];
		list_cells[at] = b;
		list_len++;
	endfunction

	function automatic void close_slot(input int at);
		for (int i = at + 1; i < list_len; i++)
			list_cells[i - 1] = list_cells[i];
		list_cells[list_len - 1] = '0;
		list_len--;
	endfunction

	function automatic list_result_t apply_request(input list_req_t r);
		list_result_t res;
		int slot;
		int pos;
		bit at_capacity;
		bit no_items;
		res.status = ST_OK;
		res.read_value = '0;
		pos = int'(r.position);
		at_capacity = list_len >= CAPACITY;
		no_items = list_len == 0;
		case (r.mode)
			MODE_PUSH_BACK: begin
				if (at_capacity) res.status = ST_FULL;
				else open_slot(list_len, r.value);
			end
			MODE_PUSH_FRONT: begin
				if (at_capacity) res.status = ST_FULL;
				else open_slot(0, r.value);
			end
			MODE_INSERT_AT: begin
				if (pos > list_len) res.status = ST_RANGE;
				else if (at_capacity) res.status = ST_FULL;
				else open_slot(pos, r.value);
			end
			MODE_INSERT_SORTED: begin
				if (at_capacity) begin
					res.status = ST_FULL;
				end else begin
					slot = 0;
					while (slot < list_len && list_cells[slot] < r.value)
						slot++;
					open_slot(slot, r.value);
				end
			end
			MODE_POP_FRONT: begin
				if (no_items) res.status = ST_EMPTY;
				else close_slot(0);
			end
			MODE_POP_BACK: begin
				if (no_items) res.status = ST_EMPTY;
				else close_slot(list_len - 1);
			end
			MODE_REMOVE_AT, MODE_REPLACE_AT, MODE_READ_AT: begin
				if (no_items) res.status = ST_EMPTY;
				else if (pos >= list_len) res.status = ST_RANGE;
				else if (r.mode == MODE_REMOVE_AT) close_slot(pos);
				else if (r.mode == MODE_REPLACE_AT) list_cells[pos] = r.value;
				else res.read_value = list_cells[pos];
			end
			MODE_CLEAR: begin
				for (int i = 0; i < CAPACITY; i++)
					list_cells[i] = '0;
				list_len = 0;
			end
			default: ;
		endcase
		if (list_len > peak_fill)
			peak_fill = list_len;
		res.item_count = list_len[CNT_OUT_W-1:0];
		if (list_len == 0) begin
			res.first_item = '0;
			res.last_item = '0;
			res.is_empty = 1'b1;
		end else begin
			res.first_item = list_cells[0];
			res.last_item = list_cells[list_len - 1];
			res.is_empty = 1'b0;
		end
		return res;
	endfunction

	task automatic queue_request(input logic [MODE_W-1:0] mode, input int pos, input int val,
			input bit hold);
		list_req_t r;
		r.mode = mode;
		r.position = pos[POS_W-1:0];
		r.value = val[VAL_W-1:0];
		r.hold_for_idle = hold;
		pending_reqs.push_back(r);
		case (mode)
			MODE_PUSH_BACK, MODE_PUSH_FRONT, MODE_INSERT_SORTED: begin
				if (gen_len < CAPACITY) gen_len++;
			end
			MODE_INSERT_AT: begin
				if (int'(r.position) <= gen_len && gen_len < CAPACITY) gen_len++;
			end
			MODE_POP_FRONT, MODE_POP_BACK: begin
				if (gen_len > 0) gen_len--;
			end
			MODE_REMOVE_AT: begin
				if (int'(r.position) < gen_len) gen_len--;
			end
			MODE_CLEAR: gen_len = 0;
			default: ;
		endcase
	endtask

	task automatic queue_random(input int kind, input bit hold);
		logic [MODE_W-1:0] mode;
		int r;
		int pos;
		int val;
		r = $urandom_range(0, 99);
		if (kind == 0) begin
			if (r < 25) mode = MODE_PUSH_BACK;
			else if (r < 45) mode = MODE_PUSH_FRONT;
			else if (r < 70) mode = MODE_INSERT_AT;
			else if (r < 92) mode = MODE_INSERT_SORTED;
			else if (r < 96) mode = MODE_READ_AT;
			else mode = MODE_REPLACE_AT;
		end else if (kind == 1) begin
			if (r < 20) mode = MODE_POP_FRONT;
			else if (r < 40) mode = MODE_POP_BACK;
			else if (r < 75) mode = MODE_REMOVE_AT;
			else if (r < 85) mode = MODE_READ_AT;
			else if (r < 95) mode = MODE_REPLACE_AT;
			else if (r < 97) mode = MODE_CLEAR;
			else mode = MODE_INSERT_AT;
		end else begin
			if (r < 3) mode = 4'($urandom_range(10, 15));
			else mode = 4'($urandom_range(0, 9));
			if (mode == MODE_CLEAR && $urandom_range(0, 3) != 0)
				mode = MODE_READ_AT;
		end
		r = $urandom_range(0, 99);
		if (r < 75) begin
			if (mode == MODE_INSERT_AT) pos = $urandom_range(0, gen_len);
			else pos = (gen_len == 0) ? 0 : $urandom_range(0, gen_len - 1);
		end else if (r < 92) begin
			pos = $urandom_range(0, CAPACITY);
		end else begin
			pos = $urandom_range(0, 127);
		end
		if ($urandom_range(0, 99) < 30) val = $urandom_range(0, 8) - 4;
		else val = $urandom_range(0, 255);
		queue_request(mode, pos, val, hold);
	endtask

	task automatic check_field(input string name, input int expv, input int actv);
		if (expv != actv) begin
			$display("%0t: %s expected %0d got %0d", $time, name, expv, actv);
			mismatches++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predicted = apply_request(held_req);
				expected_results.push_back(predicted);
				sent_count++;
				case (predicted.status)
					ST_FULL: full_rejects++;
					ST_RANGE: range_rejects++;
					ST_EMPTY: empty_rejects++;
					default: ;
				endcase
			end
			if (s_tvalid && !s_tready) begin
				// hold the word until taken
			end else if (gap_left != 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_reqs.size() != 0 &&
					!(pending_reqs[0].hold_for_idle && sent_count != got_count)) begin
				head_req = pending_reqs.pop_front();
				held_req <= head_req;
				s_tdata <= {{(IN_W - MODE_W - POS_W - VAL_W){1'b0}}, head_req.value,
					head_req.position, head_req.mode};
				s_tvalid <= 1'b1;
				gap_left <= idle_cycles(sent_count);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			out_stall <= 0;
			got_count <= 0;
		end else if (m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result word with nothing expected, got %h", $time, m_tdata);
				mismatches++;
			end else begin
				predicted = expected_results.pop_front();
				check_field("status", predicted.status, m_tdata[1:0]);
				check_field("read_value", predicted.read_value, $signed(m_tdata[9:2]));
				check_field("item_count", predicted.item_count, m_tdata[16:10]);
				check_field("first_item", predicted.first_item, $signed(m_tdata[24:17]));
				check_field("last_item", predicted.last_item, $signed(m_tdata[32:25]));
				check_field("is_empty", predicted.is_empty, m_tdata[33]);
			end
			got_count <= got_count + 1;
			out_stall <= idle_cycles(got_count + 7);
			m_tready <= 1'b0;
		end else if (out_stall != 0) begin
			out_stall <= out_stall - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		int kind;
		int run;
		int issued;
		for (int i = 0; i < CAPACITY; i++)
			list_cells[i] = '0;

		// empty list, bad index and unused mode cases around a small list
		queue_request(MODE_READ_AT, 0, 0, 1'b0);
		queue_request(MODE_POP_FRONT, 0, 0, 1'b0);
		queue_request(MODE_POP_BACK, 0, 0, 1'b0);
		queue_request(MODE_REMOVE_AT, 0, 0, 1'b0);
		queue_request(MODE_REPLACE_AT, 0, 5, 1'b0);
		queue_request(MODE_INSERT_AT, 1, 9, 1'b0);
		queue_request(MODE_PUSH_BACK, 0, -128, 1'b0);
		queue_request(MODE_PUSH_FRONT, 0, 127, 1'b0);
		queue_request(MODE_INSERT_AT, 2, 0, 1'b0);
		queue_request(MODE_INSERT_AT, 127, 3, 1'b0);
		queue_request(MODE_INSERT_SORTED, 0, -1, 1'b0);
		queue_request(MODE_INSERT_SORTED, 0, 127, 1'b0);
		queue_request(MODE_INSERT_SORTED, 0, -128, 1'b0);
		queue_request(MODE_READ_AT, 0, 0, 1'b0);
		queue_request(MODE_READ_AT, 5, 0, 1'b0);
		queue_request(MODE_READ_AT, 64, 0, 1'b0);
		queue_request(MODE_REPLACE_AT, 1, 85, 1'b0);
		queue_request(MODE_REPLACE_AT, 2, -86, 1'b0);
		queue_request(MODE_REMOVE_AT, 0, 0, 1'b0);
		queue_request(MODE_REMOVE_AT, 64, 0, 1'b0);
		queue_request(MODE_POP_BACK, 0, 0, 1'b0);
		queue_request(MODE_POP_FRONT, 0, 0, 1'b0);
		queue_request(4'd10, 33, -7, 1'b0);
		queue_request(4'd15, 127, 127, 1'b0);
		queue_request(MODE_CLEAR, 0, 0, 1'b0);

		// fill to capacity and beyond, then random phases
		issued = 0;
		for (int i = 0; i < 72; i++) begin
			queue_random(0, i == 0);
			issued++;
		end
		queue_request(MODE_INSERT_AT, 10, 1, 1'b0);
		queue_request(MODE_INSERT_AT, CAPACITY + 1, 1, 1'b0);
		queue_request(MODE_READ_AT, CAPACITY - 1, 0, 1'b0);
		queue_request(MODE_READ_AT, CAPACITY, 0, 1'b0);
		issued += 4;
		while (issued < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			kind = (kind < 4) ? 0 : (kind < 7) ? 1 : 2;
			run = $urandom_range(10, 60);
			for (int i = 0; i < run; i++) begin
				queue_random(kind, $urandom_range(0, 59) == 0);
				issued++;
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || s_tvalid || got_count != sent_count)
			@(posedge clk);
		repeat (400) @(posedge clk);

		if (expected_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				expected_results.size());
			mismatches++;
		end
		$display("ran %0d requests and checked %0d results, list reached %0d of %0d",
			sent_count, got_count, peak_fill, CAPACITY);
		$display("rejected as full %0d, bad index %0d, empty %0d",
			full_rejects, range_rejects, empty_rejects);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/ible_pkg.sv
hdl/ible_dp.sv
hdl/ible_ctrl.sv
hdl/indexed_byte_list_engine_top.sv
dv/testbench.sv
